// ----- rtl/lpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lpt_pkg;

  localparam int DefMaxJobs    = 64;
  localparam int DefMaxWorkers = 16;

  localparam int SizeW  = 48;
  localparam int LoadW  = 54;
  localparam int MinW   = 31;
  localparam int MaxWrkW = 5;
  localparam int CoreW  = 7;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_MAX_WORKERS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CORE_COUNT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_BYTES   = 2'd2;

  localparam logic [MaxWrkW-1:0] RstMaxWorkers = 5'd16;
  localparam logic [CoreW-1:0]   RstCoreCount  = 7'd4;
  localparam logic [MinW-1:0]    RstMinBytes   = 31'd6291456;

  typedef enum logic [2:0] {
    S_LOAD,
    S_QUOT,
    S_DECL,
    S_ASSIGN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic insert;
    logic rotate;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/lpt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lpt_cell #(
  parameter int IW = 6,
  parameter int WW = 4
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  lpt_pkg::cell_ctl_t        ctl,
  input  wire [lpt_pkg::SizeW-1:0]  new_size,
  input  wire [IW-1:0]              new_idx,
  input  wire                       prev_ge,
  input  wire                       prev_valid,
  input  wire [lpt_pkg::SizeW-1:0]  prev_size,
  input  wire [IW-1:0]              prev_idx,
  input  wire                       next_valid,
  input  wire [lpt_pkg::SizeW-1:0]  next_size,
  input  wire [IW-1:0]              next_idx,
  input  wire [WW-1:0]              next_wrk,
  output logic                      valid,
  output logic [lpt_pkg::SizeW-1:0] size,
  output logic [IW-1:0]             idx,
  output logic [WW-1:0]             wrk,
  output logic                      ge
);
  import lpt_pkg::*;

  logic              valid_r, valid_nxt;
  logic [SizeW-1:0]  size_r, size_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [WW-1:0]     wrk_r, wrk_nxt;

  assign ge = valid_r && (size_r >= new_size);

  always_comb begin
    valid_nxt = valid_r;
    size_nxt  = size_r;
    idx_nxt   = idx_r;
    wrk_nxt   = wrk_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.insert) begin
      if (!ge) begin
        if (prev_ge) begin
          valid_nxt = 1'b1;
          size_nxt  = new_size;
          idx_nxt   = new_idx;
        end else begin
          valid_nxt = prev_valid;
          size_nxt  = prev_size;
          idx_nxt   = prev_idx;
        end
        wrk_nxt = '0;
      end
    end else if (ctl.rotate) begin
      valid_nxt = next_valid;
      size_nxt  = next_size;
      idx_nxt   = next_idx;
      wrk_nxt   = next_wrk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    size_r <= size_nxt;
    idx_r  <= idx_nxt;
    wrk_r  <= wrk_nxt;
  end

  assign valid = valid_r;
  assign size  = size_r;
  assign idx   = idx_r;
  assign wrk   = wrk_r;

endmodule
`default_nettype wire

// ----- rtl/lpt_job_balancer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Ports
// in      | input     | in_valid, in_stall, in_job_bytes, in_last
// out     | output    | out_valid, out_stall, out_accepted .. out_end_of_run
// cfg     | input     | cfg_wr_en, cfg_index, cfg_wdata
//
// Job items load at one per cycle into a sorting chain of MAX_JOBS cells.
// After the last item the worker count is found, each job is assigned in turn to the
// least-loaded worker, and emission rotates the chain once per worker, holding while
// the output is stalled; a set with one worker or fewer gives one declined result instead.
// Input is stalled from the last item until the chain is cleared at the end of the set.
// Reset is synchronous and clears the chain valid flags, job count, byte total and loads.
module lpt_job_balancer #(
  parameter int MAX_JOBS    = lpt_pkg::DefMaxJobs,
  parameter int MAX_WORKERS = lpt_pkg::DefMaxWorkers
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [lpt_pkg::SizeW-1:0]     in_job_bytes,
  input  wire                          in_last,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_accepted,
  output logic [3:0]                   out_worker,
  output logic [5:0]                   out_job_index,
  output logic [lpt_pkg::SizeW-1:0]    out_job_size,
  output logic [lpt_pkg::LoadW-1:0]    out_worker_load,
  output logic [4:0]                   out_worker_count,
  output logic                         out_end_of_run,
  input  wire                          cfg_wr_en,
  input  wire [lpt_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire [lpt_pkg::MinW-1:0]      cfg_wdata
);
  import lpt_pkg::*;

  localparam int IW  = $clog2(MAX_JOBS);
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int WW  = $clog2(MAX_WORKERS);
  localparam int WCW = $clog2(MAX_WORKERS + 1);
  localparam int BW  = (CW > CoreW) ? CW : CoreW;

  logic [MaxWrkW-1:0] max_workers_r;
  logic [CoreW-1:0]   core_count_r;
  logic [MinW-1:0]    min_bytes_r;

  state_t state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [LoadW-1:0]   total_r, total_nxt;
  logic [LoadW:0]     acc_r, acc_nxt;
  logic [WCW-1:0]     wc_r, wc_nxt;
  logic [WCW-1:0]     scan_r, scan_nxt;
  logic [WW-1:0]      best_r, best_nxt;
  logic [LoadW-1:0]   best_load_r, best_load_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic [WW-1:0]      ew_r, ew_nxt;
  logic [CW-1:0]      emitted_r, emitted_nxt;
  logic [LoadW-1:0]   load_r [MAX_WORKERS];
  logic [LoadW-1:0]   load_nxt [MAX_WORKERS];

  logic               out_valid_r, out_valid_nxt;
  logic               o_acc_r, o_acc_nxt, o_end_r, o_end_nxt;
  logic [3:0]         o_wrk_r, o_wrk_nxt;
  logic [5:0]         o_idx_r, o_idx_nxt;
  logic [SizeW-1:0]   o_size_r, o_size_nxt;
  logic [LoadW-1:0]   o_load_r, o_load_nxt;
  logic [4:0]         o_wc_r, o_wc_nxt;

  cell_ctl_t          ctl;
  logic               c_valid [MAX_JOBS];
  logic [SizeW-1:0]   c_size  [MAX_JOBS];
  logic [IW-1:0]      c_idx   [MAX_JOBS];
  logic [WW-1:0]      c_wrk   [MAX_JOBS];
  logic               c_ge    [MAX_JOBS];
  logic [WW-1:0]      head_wrk;

  logic               in_acc, slot_free, room;
  logic [BW-1:0]      cap_b;
  logic [WCW-1:0]     cap, fin;
  logic [LoadW:0]     acc_sum;

  genvar g;
  generate
    for (g = 0; g < MAX_JOBS; g++) begin : g_cell
      logic               p_ge, p_valid, n_valid;
      logic [SizeW-1:0]   p_size, n_size;
      logic [IW-1:0]      p_idx, n_idx;
      logic [WW-1:0]      n_wrk;
      if (g == 0) begin : g_first
        assign p_ge    = 1'b1;
        assign p_valid = c_valid[0];
        assign p_size  = c_size[0];
        assign p_idx   = c_idx[0];
      end else begin : g_mid
        assign p_ge    = c_ge[g-1];
        assign p_valid = c_valid[g-1];
        assign p_size  = c_size[g-1];
        assign p_idx   = c_idx[g-1];
      end
      if (g == MAX_JOBS - 1) begin : g_last
        assign n_valid = c_valid[0];
        assign n_size  = c_size[0];
        assign n_idx   = c_idx[0];
        assign n_wrk   = head_wrk;
      end else begin : g_inner
        assign n_valid = c_valid[g+1];
        assign n_size  = c_size[g+1];
        assign n_idx   = c_idx[g+1];
        assign n_wrk   = c_wrk[g+1];
      end
      lpt_cell #(.IW(IW), .WW(WW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_size   (in_job_bytes),
        .new_idx    (IW'(count_r)),
        .prev_ge    (p_ge),
        .prev_valid (p_valid),
        .prev_size  (p_size),
        .prev_idx   (p_idx),
        .next_valid (n_valid),
        .next_size  (n_size),
        .next_idx   (n_idx),
        .next_wrk   (n_wrk),
        .valid      (c_valid[g]),
        .size       (c_size[g]),
        .idx        (c_idx[g]),
        .wrk        (c_wrk[g]),
        .ge         (c_ge[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_workers_r <= RstMaxWorkers;
      core_count_r  <= RstCoreCount;
      min_bytes_r   <= RstMinBytes;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_WORKERS: max_workers_r <= cfg_wdata[MaxWrkW-1:0];
        CFG_CORE_COUNT:  core_count_r  <= cfg_wdata[CoreW-1:0];
        CFG_MIN_BYTES:   min_bytes_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign room      = (count_r < CW'(MAX_JOBS));
  assign acc_sum   = acc_r + (LoadW+1)'(min_bytes_r);

  always_comb begin
    cap_b = BW'(max_workers_r);
    if (BW'(MAX_WORKERS) < cap_b) cap_b = BW'(MAX_WORKERS);
    if (BW'(core_count_r) < cap_b) cap_b = BW'(core_count_r);
    if (BW'(count_r) < cap_b) cap_b = BW'(count_r);
    cap = WCW'(cap_b);
    fin = (min_bytes_r == '0) ? cap : wc_r;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r;
    wc_nxt        = wc_r;
    scan_nxt      = scan_r;
    best_nxt      = best_r;
    best_load_nxt = best_load_r;
    pos_nxt       = pos_r;
    ew_nxt        = ew_r;
    emitted_nxt   = emitted_r;
    load_nxt      = load_r;
    ctl           = '0;
    head_wrk      = c_wrk[0];
    out_valid_nxt = out_valid_r && out_stall;
    o_acc_nxt     = o_acc_r;
    o_end_nxt     = o_end_r;
    o_wrk_nxt     = o_wrk_r;
    o_idx_nxt     = o_idx_r;
    o_size_nxt    = o_size_r;
    o_load_nxt    = o_load_r;
    o_wc_nxt      = o_wc_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (room) begin
            ctl.insert = 1'b1;
            count_nxt  = count_r + 1'b1;
            total_nxt  = total_r + LoadW'(in_job_bytes);
          end
          if (in_last) begin
            state_nxt = S_QUOT;
            acc_nxt   = '0;
            wc_nxt    = '0;
          end
        end
      end
      S_QUOT: begin
        if (min_bytes_r == '0 || wc_r == cap || acc_sum > {1'b0, total_r}) begin
          wc_nxt   = fin;
          scan_nxt = '0;
          pos_nxt  = '0;
          state_nxt = (fin <= WCW'(1)) ? S_DECL : S_ASSIGN;
        end else begin
          acc_nxt = acc_sum;
          wc_nxt  = wc_r + 1'b1;
        end
      end
      S_DECL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_acc_nxt  = 1'b0;
          o_end_nxt  = 1'b1;
          o_wrk_nxt  = '0;
          o_idx_nxt  = '0;
          o_size_nxt = '0;
          o_load_nxt = '0;
          o_wc_nxt   = '0;
          ctl.clear  = 1'b1;
          count_nxt  = '0;
          total_nxt  = '0;
          state_nxt  = S_LOAD;
        end
      end
      S_ASSIGN: begin
        if (!c_valid[0] || scan_r == wc_r) begin
          if (c_valid[0]) begin
            head_wrk = best_r;
            load_nxt[best_r] = best_load_r + LoadW'(c_size[0]);
          end
          ctl.rotate = 1'b1;
          scan_nxt   = '0;
          pos_nxt    = pos_r + 1'b1;
          if (pos_r == IW'(MAX_JOBS - 1)) begin
            pos_nxt     = '0;
            ew_nxt      = '0;
            emitted_nxt = '0;
            state_nxt   = S_EMIT;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
          if (scan_r == '0 || load_r[WW'(scan_r)] < best_load_r) begin
            best_nxt      = WW'(scan_r);
            best_load_nxt = load_r[WW'(scan_r)];
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          if (c_valid[0] && c_wrk[0] == ew_r) begin
            out_valid_nxt = 1'b1;
            o_acc_nxt   = 1'b1;
            o_wrk_nxt   = 4'(ew_r);
            o_idx_nxt   = 6'(c_idx[0]);
            o_size_nxt  = c_size[0];
            o_load_nxt  = load_r[ew_r];
            o_wc_nxt    = 5'(wc_r);
            o_end_nxt   = (emitted_r + 1'b1 == count_r);
            emitted_nxt = emitted_r + 1'b1;
          end
          ctl.rotate = 1'b1;
          pos_nxt    = pos_r + 1'b1;
          if (pos_r == IW'(MAX_JOBS - 1)) begin
            pos_nxt = '0;
            ew_nxt  = ew_r + 1'b1;
            if (WCW'(ew_r) + 1'b1 == wc_r) begin
              ctl.rotate = 1'b0;
              ctl.clear  = 1'b1;
              count_nxt  = '0;
              total_nxt  = '0;
              for (int w = 0; w < MAX_WORKERS; w++) begin
                load_nxt[w] = '0;
              end
              state_nxt = S_LOAD;
            end
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int w = 0; w < MAX_WORKERS; w++) begin
        load_r[w] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      load_r      <= load_nxt;
    end
    acc_r       <= acc_nxt;
    wc_r        <= wc_nxt;
    scan_r      <= scan_nxt;
    best_r      <= best_nxt;
    best_load_r <= best_load_nxt;
    pos_r       <= pos_nxt;
    ew_r        <= ew_nxt;
    emitted_r   <= emitted_nxt;
    o_acc_r     <= o_acc_nxt;
    o_end_r     <= o_end_nxt;
    o_wrk_r     <= o_wrk_nxt;
    o_idx_r     <= o_idx_nxt;
    o_size_r    <= o_size_nxt;
    o_load_r    <= o_load_nxt;
    o_wc_r      <= o_wc_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = o_acc_r;
  assign out_worker       = o_wrk_r;
  assign out_job_index    = o_idx_r;
  assign out_job_size     = o_size_r;
  assign out_worker_load  = o_load_r;
  assign out_worker_count = o_wc_r;
  assign out_end_of_run   = o_end_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_JOBS))
    else $error("job count above capacity");

  a_emit_wc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ASSIGN || state_r == S_EMIT) |-> wc_r >= WCW'(2))
    else $error("split run with fewer than two workers");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ASSIGN |-> scan_r <= wc_r)
    else $error("worker scan ran past worker count");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD && state_nxt == S_LOAD) |=> count_r == '0 && total_r == '0)
    else $error("set state not cleared at end of run");

endmodule
`default_nettype wire

// ----- sim/tb_lpt_job_balancer.sv -----
`timescale 1ns / 1ps
module tb_lpt_job_balancer;
  import lpt_pkg::*;

  typedef struct {
    logic              accepted;
    logic [3:0]        worker;
    logic [5:0]        job_index;
    logic [SizeW-1:0]  job_size;
    logic [LoadW-1:0]  worker_load;
    logic [4:0]        worker_count;
    logic              end_of_run;
  } split_t;

  class split_scoreboard;
    split_t            awaited[$];
    logic [MaxWrkW-1:0] max_wrk;
    logic [CoreW-1:0]  cores;
    logic [MinW-1:0]   min_bytes;
    logic [SizeW-1:0]  sizes[DefMaxJobs];
    int                order[DefMaxJobs];
    int                owner[DefMaxJobs];
    logic [63:0]       load[DefMaxWorkers];
    logic [63:0]       total;
    int                njobs;
    int                errors;
    int                sets;
    int                declined;
    int                checked;

    function new();
      max_wrk = RstMaxWorkers;
      cores = RstCoreCount;
      min_bytes = RstMinBytes;
      total = 0;
      njobs = 0;
      errors = 0;
      sets = 0;
      declined = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [MinW-1:0] val);
      case (idx)
        CFG_MAX_WORKERS: max_wrk = val[MaxWrkW-1:0];
        CFG_CORE_COUNT:  cores = val[CoreW-1:0];
        CFG_MIN_BYTES:   min_bytes = val;
        default: ;
      endcase
    endfunction

    function void note_job(logic [SizeW-1:0] bytes, logic last);
      split_t r;
      logic [63:0] wc;
      int k, best, emitted;
      if (njobs < DefMaxJobs) begin
        sizes[njobs] = bytes;
        total += bytes;
        njobs++;
      end
      if (!last) return;
      sets++;
      if (max_wrk <= 1 || cores <= 1 || njobs <= 1 || total < 2 * 64'(min_bytes)) begin
        r = '{1'b0, 4'd0, 6'd0, '0, '0, 5'd0, 1'b1};
        awaited.push_back(r);
        declined++;
      end else begin
        wc = (max_wrk < DefMaxWorkers) ? max_wrk : DefMaxWorkers;
        if (cores < wc) wc = cores;
        if (njobs < wc) wc = njobs;
        if (min_bytes != 0 && total / min_bytes < wc) wc = total / min_bytes;
        for (int i = 0; i < njobs; i++) begin
          k = i;
          while (k > 0 && sizes[order[k-1]] < sizes[i]) begin
            order[k] = order[k-1];
            k--;
          end
          order[k] = i;
        end
        for (int w = 0; w < DefMaxWorkers; w++) load[w] = 0;
        for (int i = 0; i < njobs; i++) begin
          best = 0;
          for (int w = 1; w < wc; w++)
            if (load[w] < load[best]) best = w;
          load[best] += sizes[order[i]];
          owner[i] = best;
        end
        emitted = 0;
        for (int w = 0; w < wc; w++)
          for (int i = 0; i < njobs; i++)
            if (owner[i] == w) begin
              emitted++;
              r = '{1'b1, w[3:0], order[i][5:0], sizes[order[i]], load[w][LoadW-1:0],
                    wc[4:0], emitted == njobs};
              awaited.push_back(r);
            end
      end
      total = 0;
      njobs = 0;
    endfunction

    function void check_result(split_t got);
      split_t e;
      checked++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, worker %0d job %0d", $time, got.worker,
                 got.job_index);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.accepted !== e.accepted) begin
        $display("%0t: accepted exp %0d got %0d", $time, e.accepted, got.accepted);
        errors++;
      end
      if (got.worker !== e.worker) begin
        $display("%0t: worker exp %0d got %0d", $time, e.worker, got.worker);
        errors++;
      end
      if (got.job_index !== e.job_index) begin
        $display("%0t: job_index exp %0d got %0d", $time, e.job_index, got.job_index);
        errors++;
      end
      if (got.job_size !== e.job_size) begin
        $display("%0t: job_size exp %0h got %0h", $time, e.job_size, got.job_size);
        errors++;
      end
      if (got.worker_load !== e.worker_load) begin
        $display("%0t: worker_load exp %0h got %0h", $time, e.worker_load,
                 got.worker_load);
        errors++;
      end
      if (got.worker_count !== e.worker_count) begin
        $display("%0t: worker_count exp %0d got %0d", $time, e.worker_count,
                 got.worker_count);
        errors++;
      end
      if (got.end_of_run !== e.end_of_run) begin
        $display("%0t: end_of_run exp %0d got %0d", $time, e.end_of_run, got.end_of_run);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [SizeW-1:0]   in_job_bytes;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic               out_accepted;
  logic [3:0]         out_worker;
  logic [5:0]         out_job_index;
  logic [SizeW-1:0]   out_job_size;
  logic [LoadW-1:0]   out_worker_load;
  logic [4:0]         out_worker_count;
  logic               out_end_of_run;
  logic               cfg_wr_en;
  logic [CfgIdxW-1:0] cfg_index;
  logic [MinW-1:0]    cfg_wdata;

  split_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int quiet;
  int items_sent;

  lpt_job_balancer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_job_bytes(in_job_bytes),
    .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_worker(out_worker), .out_job_index(out_job_index),
    .out_job_size(out_job_size), .out_worker_load(out_worker_load),
    .out_worker_count(out_worker_count), .out_end_of_run(out_end_of_run),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_accepted, out_worker, out_job_index, out_job_size,
                        out_worker_load, out_worker_count, out_end_of_run});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= 40000) begin
      $display("%0t: no progress, run stopped", $time);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_job(logic [SizeW-1:0] bytes, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_job_bytes <= bytes;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_job(bytes, last);
    items_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [MinW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [SizeW-1:0] pick_size(int kind);
    case (kind)
      0: return SizeW'($urandom_range(0, 4194304));
      1: return SizeW'($urandom_range(0, 32'h7fff_ffff));
      2: return SizeW'({$urandom, $urandom});
      default: return 48'd8388608;
    endcase
  endfunction

  task automatic send_set(int len, int kind);
    for (int i = 0; i < len; i++)
      send_job(pick_size(kind == 4 ? $urandom_range(3) : kind), i == len - 1);
  endtask

  initial begin
    logic [MinW-1:0] phase_cfg[7][3];
    int len;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_job_bytes = 0;
    in_last = 0;
    out_stall = 0;
    cfg_wr_en = 0;
    cfg_index = CFG_MAX_WORKERS;
    cfg_wdata = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    quiet = 0;
    items_sent = 0;
    phase_cfg = '{'{16, 4, 6291456}, '{2, 64, 1}, '{16, 64, 0}, '{31, 127, 31'h7fffffff},
                  '{8, 1, 1000}, '{1, 16, 0}, '{0, 0, 31'h2aaaaaaa}};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short directed sets under reset configuration.
    send_job(48'd7340032, 1'b1);
    send_job(48'hffff_ffff_ffff, 1'b0);
    send_job(48'hffff_ffff_ffff, 1'b1);
    send_job(0, 1'b0);
    send_job(0, 1'b1);
    for (int i = 0; i < 5; i++) send_job(48'd8388608, i == 4);
    for (int i = 0; i < 4; i++) send_job(48'd100 << (i * 10), 1'b0);
    send_job(48'd6291456, 1'b1);
    send_job(48'd6291455, 1'b0);
    send_job(48'd6291456, 1'b1);
    drain();

    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_MAX_WORKERS, phase_cfg[p][0]);
      write_reg(CFG_CORE_COUNT, phase_cfg[p][1]);
      write_reg(CFG_MIN_BYTES, phase_cfg[p][2]);
      if (p == 3) write_reg(2'd3, 31'h1234);
      cfg_wr_en <= 1'b0;
      send_idle_pct = (p % 4 == 1) ? 52 : (p % 4 == 3) ? 21 : 0;
      recv_stall_pct = (p % 4 == 2) ? 52 : (p % 4 == 3) ? 21 : 0;
      if (p == 1) hold_cycles = 400;
      while (items_sent < 18 + (p + 1) * 65) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 10);
        send_set(len, $urandom_range(4));
      end
      drain();
    end

    $display("Sent %0d jobs in %0d sets over 7 settings, %0d sets declined.",
             items_sent, sb.sets, sb.declined);
    $display("Checked %0d results with %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
